// ===== rtl/prefix_code_bit_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Prefix code bit decoder assertion macros
// Shared property forms for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_BIT_DECODER_CORE_ASSERT_SVH
`define PREFIX_CODE_BIT_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define PCBD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcbd assertion failed");

// next-cycle implication
`define PCBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcbd assertion failed");

`endif

// ===== rtl/pcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Prefix code bit decoder package
// Shared constants, command and state codes, and table and result types.
// ----------------------------------------------------------------------------
package pcbd_pkg;

   localparam int DefTableEntries = 256;
   localparam int DefMaxCodeBits  = 32;
   localparam int MaxSymbolBytes  = 4;
   localparam int ByteBits        = 8;

   localparam int IndexW    = 8;
   localparam int CodeW     = 32;
   localparam int CodeLenW  = 6;
   localparam int SymW      = 32;
   localparam int SymLenW   = 3;
   localparam int BitCntW   = 4;
   localparam int ReqDataW  = 96;
   localparam int RspDataW  = 40;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_DECODE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SCAN,
      ST_STORE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [CodeW-1:0]    code;
      logic [CodeLenW-1:0] code_len;
      logic [SymW-1:0]     sym;
      logic [SymLenW-1:0]  sym_len;
   } entry_type;

   typedef struct packed {
      logic [SymW-1:0]    sym;
      logic [SymLenW-1:0] len;
      logic               ovf;
   } result_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic clear;
   } code_ctrl_type;

   typedef struct packed {
      logic more_bits;
      logic full;
      logic match;
   } code_status_type;

endpackage

// ===== rtl/pcbd_table.sv =====
// ----------------------------------------------------------------------------
// Prefix code bit decoder match table
// Slot memory with per-slot valid flags, one write and one registered read.
// ----------------------------------------------------------------------------
module pcbd_table #(
   parameter int  TABLE_ENTRIES = pcbd_pkg::DefTableEntries,
   localparam int IdxW          = $clog2(TABLE_ENTRIES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [pcbd_pkg::IndexW-1:0] wr_index,
   input  logic                        wr_valid,
   input  pcbd_pkg::entry_type         wr_entry,
   input  logic [IdxW-1:0]             rd_addr,
   output logic                        rd_valid_ff,
   output pcbd_pkg::entry_type         rd_entry_ff
);

   localparam int AddrW = (IdxW > pcbd_pkg::IndexW) ? IdxW : pcbd_pkg::IndexW;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   pcbd_pkg::entry_type      slot_mem [TABLE_ENTRIES];

   logic [AddrW-1:0]                wide_idx;
   logic [IdxW-1:0]                 wr_addr;
   logic                            in_range;
   logic [pcbd_pkg::SymLenW-1:0]    sat_len;
   pcbd_pkg::entry_type             store_entry;

   assign wide_idx = AddrW'(wr_index);
   assign wr_addr  = wide_idx[IdxW-1:0];
   assign in_range = (32'(wr_index) < TABLE_ENTRIES);

   always_comb begin
      sat_len = (wr_entry.sym_len > pcbd_pkg::SymLenW'(pcbd_pkg::MaxSymbolBytes)) ?
                pcbd_pkg::SymLenW'(pcbd_pkg::MaxSymbolBytes) : wr_entry.sym_len;
      store_entry         = wr_entry;
      store_entry.sym_len = sat_len;
      for (int b = 0; b < pcbd_pkg::SymW / pcbd_pkg::ByteBits; b++) begin
         if (pcbd_pkg::SymLenW'(b) >= sat_len) begin
            store_entry.sym[b*pcbd_pkg::ByteBits +: pcbd_pkg::ByteBits] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en && in_range) begin
            valid_ff[wr_addr] <= wr_valid;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && in_range) begin
         slot_mem[wr_addr] <= store_entry;
      end
      rd_entry_ff <= slot_mem[rd_addr];
   end

endmodule

// ===== rtl/pcbd_code_reg.sv =====
// ----------------------------------------------------------------------------
// Prefix code bit decoder code register
// Serializes the data byte MSB first into the partial code, length and mask
// shift registers, and compares the partial code with one table slot.
// ----------------------------------------------------------------------------
module pcbd_code_reg #(
   parameter int  MAX_CODE_BITS = pcbd_pkg::DefMaxCodeBits,
   localparam int LenW          = $clog2(MAX_CODE_BITS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pcbd_pkg::code_ctrl_type       ctrl,
   input  logic [pcbd_pkg::ByteBits-1:0] data_byte,
   input  logic [pcbd_pkg::BitCntW-1:0]  valid_bits,
   input  logic                          ent_valid,
   input  pcbd_pkg::entry_type           ent,
   output pcbd_pkg::code_status_type     status
);

   localparam int PW = (MAX_CODE_BITS > pcbd_pkg::CodeW) ? MAX_CODE_BITS : pcbd_pkg::CodeW;
   localparam int CW = (LenW > pcbd_pkg::CodeLenW) ? LenW : pcbd_pkg::CodeLenW;

   logic [pcbd_pkg::ByteBits-1:0] byte_ff;
   logic [pcbd_pkg::BitCntW-1:0]  cnt_ff;
   logic [MAX_CODE_BITS-1:0]      code_ff;
   logic [MAX_CODE_BITS-1:0]      mask_ff;
   logic [LenW-1:0]               len_ff;
   logic [pcbd_pkg::BitCntW-1:0]  nbits;

   assign nbits = (valid_bits > pcbd_pkg::BitCntW'(pcbd_pkg::ByteBits)) ?
                  pcbd_pkg::BitCntW'(pcbd_pkg::ByteBits) : valid_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
         cnt_ff  <= '0;
         code_ff <= '0;
         mask_ff <= '0;
         len_ff  <= '0;
      end else if (ctrl.load) begin
         byte_ff <= data_byte << (pcbd_pkg::BitCntW'(pcbd_pkg::ByteBits) - nbits);
         cnt_ff  <= nbits;
      end else if (ctrl.shift) begin
         byte_ff <= {byte_ff[pcbd_pkg::ByteBits-2:0], 1'b0};
         cnt_ff  <= cnt_ff - 1'b1;
         code_ff <= {code_ff[MAX_CODE_BITS-2:0], byte_ff[pcbd_pkg::ByteBits-1]};
         mask_ff <= {mask_ff[MAX_CODE_BITS-2:0], 1'b1};
         len_ff  <= len_ff + 1'b1;
      end else if (ctrl.clear) begin
         code_ff <= '0;
         mask_ff <= '0;
         len_ff  <= '0;
      end
   end

   always_comb begin
      status.more_bits = (cnt_ff != '0);
      status.full      = (len_ff >= LenW'(MAX_CODE_BITS));
      status.match     = ent_valid &&
                         (CW'(ent.code_len) == CW'(len_ff)) &&
                         ((PW'(ent.code) & PW'(mask_ff)) == PW'(code_ff));
   end

endmodule

// ===== rtl/prefix_code_bit_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Prefix code bit decoder core
// Loads a prefix code match table and decodes a bit stream into symbols.
//
//   channel   direction   carries
//   req_*     in          table load or data byte request
//   rsp_*     out         decoded symbol or overflow error
//
// A load request is taken in the idle state. A data byte is taken in idle,
// then for each valid bit the decoder shifts the bit in and scans table slots
// (slots are read one per cycle from the table memory, stopping at the first
// match), stores a result on a match or overflow, and then closes in a flush state.
// Reset clears slot valid flags at once; no clearing pass. A stalled rsp side
// holds the decoder once its two-deep result buffer is full.
// ----------------------------------------------------------------------------
module prefix_code_bit_decoder_core #(
   parameter int TABLE_ENTRIES = pcbd_pkg::DefTableEntries,
   parameter int MAX_CODE_BITS = pcbd_pkg::DefMaxCodeBits
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // entry_index, entry_valid, code_value, code_length, symbol_value,
   // symbol_length, data_byte, valid_bits
   input  logic [pcbd_pkg::ReqDataW-1:0] req_tdata,
   // command
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // decoded_symbol, decoded_length
   output logic [pcbd_pkg::RspDataW-1:0] rsp_tdata,
   // overflow_error
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);

   localparam int IdxW = $clog2(TABLE_ENTRIES);

   pcbd_pkg::state_type        state_ff, state_in;
   logic [IdxW-1:0]            scan_ff, scan_in;
   pcbd_pkg::result_type       res_ff, res_in;
   pcbd_pkg::result_type       pend_ff, pend_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic                       out_valid_ff;
   pcbd_pkg::result_type       out_res_ff;
   logic                       out_last_ff;

   logic                       push;
   logic                       push_last;
   logic                       slot_free;
   logic                       wr_en;
   logic [IdxW-1:0]            rd_addr;
   pcbd_pkg::code_ctrl_type    ctrl;
   pcbd_pkg::code_status_type  status;
   pcbd_pkg::entry_type        wr_entry;
   pcbd_pkg::entry_type        rd_entry;
   logic                       rd_valid;

   logic [pcbd_pkg::IndexW-1:0]   entry_index;
   logic                          entry_valid;
   logic [pcbd_pkg::ByteBits-1:0] data_byte;
   logic [pcbd_pkg::BitCntW-1:0]  valid_bits;

   assign entry_index       = req_tdata[7:0];
   assign entry_valid       = req_tdata[8];
   assign wr_entry.code     = req_tdata[40:9];
   assign wr_entry.code_len = req_tdata[46:41];
   assign wr_entry.sym      = req_tdata[78:47];
   assign wr_entry.sym_len  = req_tdata[81:79];
   assign data_byte         = req_tdata[89:82];
   assign valid_bits        = req_tdata[93:90];

   pcbd_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (wr_en),
      .wr_index    (entry_index),
      .wr_valid    (entry_valid),
      .wr_entry    (wr_entry),
      .rd_addr     (rd_addr),
      .rd_valid_ff (rd_valid),
      .rd_entry_ff (rd_entry)
   );

   pcbd_code_reg #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_code_reg (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .data_byte  (data_byte),
      .valid_bits (valid_bits),
      .ent_valid  (rd_valid),
      .ent        (rd_entry),
      .status     (status)
   );

   assign slot_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pcbd_pkg::ST_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         if (push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      res_ff  <= res_in;
      pend_ff <= pend_in;
      if (push) begin
         out_res_ff  <= pend_ff;
         out_last_ff <= push_last;
      end
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      res_in        = res_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      req_tready    = 1'b0;
      wr_en         = 1'b0;
      ctrl          = '0;
      rd_addr       = scan_ff + 1'b1;
      push          = 1'b0;
      push_last     = 1'b0;
      unique case (state_ff)
         pcbd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (pcbd_pkg::cmd_type'(req_tuser) == pcbd_pkg::CMD_LOAD) begin
                  wr_en = 1'b1;
               end else begin
                  ctrl.load = 1'b1;
                  if (valid_bits != '0) begin
                     state_in = pcbd_pkg::ST_SHIFT;
                  end
               end
            end
         end
         pcbd_pkg::ST_SHIFT: begin
            ctrl.shift = 1'b1;
            rd_addr    = '0;
            scan_in    = '0;
            state_in   = pcbd_pkg::ST_SCAN;
         end
         pcbd_pkg::ST_SCAN: begin
            if (status.match) begin
               res_in.sym = rd_entry.sym;
               res_in.len = rd_entry.sym_len;
               res_in.ovf = 1'b0;
               ctrl.clear = 1'b1;
               state_in   = pcbd_pkg::ST_STORE;
            end else if (scan_ff == IdxW'(TABLE_ENTRIES - 1)) begin
               if (status.full) begin
                  res_in.sym = '0;
                  res_in.len = '0;
                  res_in.ovf = 1'b1;
                  ctrl.clear = 1'b1;
                  state_in   = pcbd_pkg::ST_STORE;
               end else begin
                  state_in = status.more_bits ? pcbd_pkg::ST_SHIFT : pcbd_pkg::ST_FLUSH;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         pcbd_pkg::ST_STORE: begin
            if (!pend_valid_ff || slot_free) begin
               push          = pend_valid_ff;
               pend_in       = res_ff;
               pend_valid_in = 1'b1;
               state_in      = status.more_bits ? pcbd_pkg::ST_SHIFT : pcbd_pkg::ST_FLUSH;
            end
         end
         pcbd_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = pcbd_pkg::ST_IDLE;
            end else if (slot_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = pcbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcbd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = pcbd_pkg::RspDataW'({out_res_ff.len, out_res_ff.sym});
   assign rsp_tuser  = out_res_ff.ovf;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/pcbd_checker.sv =====
// ----------------------------------------------------------------------------
// Prefix code bit decoder port checker
// Watches the decoder's ports for result and reset behavior.
// ----------------------------------------------------------------------------
`include "prefix_code_bit_decoder_core_assert.svh"

module pcbd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [pcbd_pkg::RspDataW-1:0] rsp_tdata,
   input logic                          rsp_tuser,
   input logic                          rsp_tlast
);

   logic                          rsp_stall;
   logic                          err_shown;
   logic [pcbd_pkg::RspDataW+1:0] rsp_word;
   logic [pcbd_pkg::SymLenW-1:0]  rsp_len;
   logic [pcbd_pkg::SymLenW-1:0]  len_max;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign err_shown = rsp_tvalid && rsp_tuser;
   assign rsp_word  = {rsp_tdata, rsp_tuser, rsp_tlast};
   assign rsp_len   = rsp_tdata[pcbd_pkg::SymW +: pcbd_pkg::SymLenW];
   assign len_max   = pcbd_pkg::SymLenW'(pcbd_pkg::MaxSymbolBytes);

   `PCBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   `PCBD_ASSERT_IMPLY(a_err_empty, clock, reset, err_shown, rsp_tdata == '0)

   `PCBD_ASSERT_IMPLY(a_len_bound, clock, reset, rsp_tvalid, rsp_len <= len_max)

   `PCBD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind prefix_code_bit_decoder_core pcbd_checker u_pcbd_checker (.*);

// ===== tb/prefix_code_bit_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// Prefix code bit decoder core testbench
// Loads match table slots and streams data bytes through the decoder. A
// scoreboard keeps its own copy of the table and the partial code register,
// predicts every symbol and overflow result and checks each result request
// in order. Both channels idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prefix_code_bit_decoder_core_tb;

   localparam int NumSlots     = pcbd_pkg::DefTableEntries;
   localparam int CodeBits     = pcbd_pkg::DefMaxCodeBits;
   localparam int QuietLimit   = 20000;
   localparam int DrainCycles  = 8 * (NumSlots + 2) + 200;
   localparam int LiveCodesMax = 12;

   typedef struct packed {
      pcbd_pkg::cmd_type             cmd;
      logic [pcbd_pkg::IndexW-1:0]   idx;
      logic                          en;
      logic [pcbd_pkg::CodeW-1:0]    code;
      logic [pcbd_pkg::CodeLenW-1:0] code_len;
      logic [pcbd_pkg::SymW-1:0]     sym;
      logic [pcbd_pkg::SymLenW-1:0]  sym_len;
      logic [7:0]                    data;
      logic [pcbd_pkg::BitCntW-1:0]  nbits;
   } req_item_type;

   typedef struct packed {
      logic [pcbd_pkg::SymW-1:0]    sym;
      logic [pcbd_pkg::SymLenW-1:0] len;
      logic                         ovf;
      logic                         last;
   } symbol_result_type;

   typedef struct {
      logic [pcbd_pkg::IndexW-1:0]   idx;
      logic [pcbd_pkg::CodeW-1:0]    code;
      logic [pcbd_pkg::CodeLenW-1:0] len;
   } live_code_type;

   class decode_scoreboard;
      logic                          cb_on[NumSlots];
      logic [pcbd_pkg::CodeW-1:0]    cb_code[NumSlots];
      logic [pcbd_pkg::CodeLenW-1:0] cb_len[NumSlots];
      logic [pcbd_pkg::SymW-1:0]     cb_sym[NumSlots];
      logic [pcbd_pkg::SymLenW-1:0]  cb_sym_len[NumSlots];
      logic [pcbd_pkg::CodeW-1:0]    shift_code;
      int                            shift_len;
      symbol_result_type             expected_symbols[$];
      int                            failures;

      function new();
         foreach (cb_on[s]) begin
            cb_on[s] = 1'b0;
         end
         shift_code = '0;
         shift_len  = 0;
         failures   = 0;
      endfunction

      function void note_request(req_item_type r);
         int                nb;
         int                produced;
         int                hit_slot;
         logic [31:0]       code_mask;
         logic [31:0]       sym_mask;
         symbol_result_type res;
         if (r.cmd == pcbd_pkg::CMD_LOAD) begin
            cb_on[r.idx]      = r.en;
            cb_code[r.idx]    = r.code;
            cb_len[r.idx]     = r.code_len;
            cb_sym[r.idx]     = r.sym;
            cb_sym_len[r.idx] = (r.sym_len > pcbd_pkg::SymLenW'(pcbd_pkg::MaxSymbolBytes)) ?
                                pcbd_pkg::SymLenW'(pcbd_pkg::MaxSymbolBytes) : r.sym_len;
            return;
         end
         nb       = (r.nbits > pcbd_pkg::ByteBits) ? pcbd_pkg::ByteBits : r.nbits;
         produced = 0;
         for (int b = nb - 1; b >= 0; b--) begin
            shift_code = {shift_code[pcbd_pkg::CodeW-2:0], r.data[b]};
            shift_len++;
            code_mask = (shift_len >= 32) ? 32'hFFFF_FFFF : ((32'h1 << shift_len) - 1);
            hit_slot  = -1;
            for (int s = 0; s < NumSlots; s++) begin
               if (cb_on[s] && cb_len[s] == shift_len && (cb_code[s] & code_mask) == shift_code)
               begin
                  hit_slot = s;
                  break;
               end
            end
            if (hit_slot >= 0) begin
               sym_mask = (cb_sym_len[hit_slot] >= pcbd_pkg::MaxSymbolBytes) ? 32'hFFFF_FFFF :
                          ((32'h1 << (8 * cb_sym_len[hit_slot])) - 1);
               res.sym  = cb_sym[hit_slot] & sym_mask;
               res.len  = cb_sym_len[hit_slot];
               res.ovf  = 1'b0;
               res.last = 1'b0;
               expected_symbols.insert(expected_symbols.size(), res);
               produced++;
               shift_code = '0;
               shift_len  = 0;
            end else if (shift_len >= CodeBits) begin
               res.sym  = '0;
               res.len  = '0;
               res.ovf  = 1'b1;
               res.last = 1'b0;
               expected_symbols.insert(expected_symbols.size(), res);
               produced++;
               shift_code = '0;
               shift_len  = 0;
            end
         end
         if (produced > 0) begin
            expected_symbols[expected_symbols.size() - 1].last = 1'b1;
         end
      endfunction

      function void check_result(logic [pcbd_pkg::SymW-1:0] sym,
                                 logic [pcbd_pkg::SymLenW-1:0] len, logic ovf, logic last);
         symbol_result_type want;
         bit                bad;
         if (expected_symbols.size() == 0) begin
            $error("unexpected result: decoded_symbol %h decoded_length %0d overflow %b",
                   sym, len, ovf);
            failures++;
            return;
         end
         want = expected_symbols.pop_front();
         bad  = 1'b0;
         if (sym !== want.sym) begin
            $error("decoded_symbol: expected %h, actual %h", want.sym, sym);
            bad = 1'b1;
         end
         if (len !== want.len) begin
            $error("decoded_length: expected %0d, actual %0d", want.len, len);
            bad = 1'b1;
         end
         if (ovf !== want.ovf) begin
            $error("overflow_error: expected %b, actual %b", want.ovf, ovf);
            bad = 1'b1;
         end
         if (last !== want.last) begin
            $error("last_of_run: expected %b, actual %b", want.last, last);
            bad = 1'b1;
         end
         if (bad) begin
            failures++;
         end
      endfunction
   endclass

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [pcbd_pkg::ReqDataW-1:0] req_tdata  = '0;
   logic                          req_tuser  = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [pcbd_pkg::RspDataW-1:0] rsp_tdata;
   logic                          rsp_tuser;
   logic                          rsp_tlast;

   decode_scoreboard sb;
   live_code_type    live[$];
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               requests_sent = 0;
   int               quiet_cycles  = 0;

   prefix_code_bit_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata[pcbd_pkg::SymW-1:0],
                         rsp_tdata[pcbd_pkg::SymW +: pcbd_pkg::SymLenW], rsp_tuser,
                         rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic req_item_type make_load(logic [7:0] idx, logic en, logic [31:0] code,
                                              logic [5:0] len, logic [31:0] sym,
                                              logic [2:0] slen);
      req_item_type r;
      r.cmd      = pcbd_pkg::CMD_LOAD;
      r.idx      = idx;
      r.en       = en;
      r.code     = code;
      r.code_len = len;
      r.sym      = sym;
      r.sym_len  = slen;
      r.data     = 8'($urandom_range(255));
      r.nbits    = 4'($urandom_range(15));
      return r;
   endfunction

   function automatic req_item_type make_decode(logic [7:0] data, logic [3:0] nbits);
      req_item_type r;
      r.cmd      = pcbd_pkg::CMD_DECODE;
      r.idx      = 8'($urandom_range(255));
      r.en       = 1'($urandom_range(1));
      r.code     = $urandom();
      r.code_len = 6'($urandom_range(63));
      r.sym      = $urandom();
      r.sym_len  = 3'($urandom_range(7));
      r.data     = data;
      r.nbits    = nbits;
      return r;
   endfunction

   // enter and leave at a falling edge
   task automatic send_request(input req_item_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = r.cmd;
      req_tdata  = {2'b00, r.nbits, r.data, r.sym_len, r.sym, r.code_len, r.code, r.en, r.idx};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.note_request(r);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic run_directed();
      // empty table: four bytes run the register into overflow
      send_request(make_decode(8'hFF, 4'd8));
      send_request(make_decode(8'h00, 4'd8));
      send_request(make_decode(8'hA5, 4'd8));
      send_request(make_decode(8'h5A, 4'd8));
      send_request(make_load(8'd0, 1'b1, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 3'd7));
      send_request(make_load(8'd255, 1'b1, 32'h0000_0000, 6'd1, 32'h1234_5678, 3'd0));
      send_request(make_load(8'd1, 1'b1, 32'h0000_0002, 6'd2, 32'hAABB_CCDD, 3'd1));
      send_request(make_load(8'd2, 1'b1, 32'h0000_0002, 6'd2, 32'h1122_3344, 3'd2));
      send_request(make_load(8'd3, 1'b1, 32'h0000_0007, 6'd0, 32'h5555_5555, 3'd3));
      send_request(make_load(8'd4, 1'b1, 32'h0000_001F, 6'd33, 32'h6666_6666, 3'd5));
      send_request(make_load(8'd5, 1'b1, 32'hFFFF_FFFF, 6'd63, 32'h7777_7777, 3'd6));
      send_request(make_load(8'd6, 1'b0, 32'h0000_0003, 6'd2, 32'h8888_8888, 3'd4));
      send_request(make_decode(8'h80, 4'd8));
      send_request(make_decode(8'h0F, 4'd15));
      send_request(make_decode(8'hFF, 4'd8));
      send_request(make_decode(8'hFF, 4'd8));
      send_request(make_decode(8'hFF, 4'd8));
      send_request(make_decode(8'hF0, 4'd8));
      send_request(make_decode(8'h00, 4'd0));
      send_request(make_decode(8'h03, 4'd2));
      send_request(make_decode(8'hAB, 4'd9));
      send_request(make_load(8'd6, 1'b1, 32'h0000_0003, 6'd2, 32'h9999_9999, 3'd4));
      send_request(make_load(8'd7, 1'b1, 32'hFFFF_FFF5, 6'd3, 32'hC3A5_0F1E, 3'd3));
      send_request(make_decode(8'hA0, 4'd8));
      send_request(make_decode(8'hDA, 4'd5));
   endtask

   task automatic add_entry(input int lo, input int hi);
      live_code_type e;
      if (live.size() >= LiveCodesMax) begin
         send_request(make_load(live[0].idx, 1'b0, $urandom(), 6'($urandom_range(63)),
                                $urandom(), 3'($urandom_range(7))));
         void'(live.pop_front());
      end
      e.idx  = 8'($urandom_range(255));
      e.code = $urandom();
      e.len  = 6'($urandom_range(lo, hi));
      send_request(make_load(e.idx, 1'b1, e.code, e.len, $urandom(),
                             ($urandom_range(9) == 0) ? 3'($urandom_range(7)) :
                             3'($urandom_range(1, 4))));
      live.insert(live.size(), e);
   endtask

   // spell out codes of live slots as a byte stream, with a little bit noise
   task automatic emit_codes(input int count);
      bit         stream[$];
      int         pick;
      int         nb;
      logic [7:0] data;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(live.size() - 1);
         for (int b = live[pick].len - 1; b >= 0; b--) begin
            stream.insert(stream.size(), live[pick].code[b]);
         end
         if ($urandom_range(5) == 0) begin
            stream.insert(stream.size(), 1'($urandom_range(1)));
         end
      end
      while (stream.size() > 0) begin
         if ($urandom_range(15) == 0) begin
            send_request(make_decode(8'($urandom_range(255)), 4'd0));
         end
         nb   = (stream.size() > pcbd_pkg::ByteBits) ? pcbd_pkg::ByteBits : stream.size();
         data = 8'($urandom_range(255));
         for (int i = 0; i < nb; i++) begin
            data = {data[6:0], stream.pop_front()};
         end
         send_request(make_decode(data, 4'(nb)));
      end
   endtask

   task automatic run_random(input int quota);
      int           start;
      int           roll;
      req_item_type r;
      start = requests_sent;
      while (requests_sent - start < quota) begin
         roll = $urandom_range(99);
         if (roll < 70) begin
            repeat ($urandom_range(1, 3)) add_entry(1, 8);
            emit_codes($urandom_range(2, 10));
         end else if (roll < 85) begin
            add_entry(9, CodeBits);
            emit_codes($urandom_range(1, 4));
         end else begin
            repeat (4) begin
               r = make_decode(8'($urandom_range(255)), 4'($urandom_range(15)));
               r.cmd = ($urandom_range(2) == 0) ? pcbd_pkg::CMD_LOAD : pcbd_pkg::CMD_DECODE;
               send_request(r);
            end
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 17;
      recv_idle_pct = 71;
      run_directed();
      run_random(150);

      send_idle_pct = 71;
      recv_idle_pct = 17;
      run_random(150);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(150);
      req_tvalid = 1'b0;

      // drain, then hold for stray results
      while (sb.expected_symbols.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);

      if (sb.failures == 0 && sb.expected_symbols.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
